// ----- rtl/core/cmm_pkg.sv -----
// Shared types and constants of the column masked mean unit.
`default_nettype none
package cmm_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned COUNT_OUT_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAD_CODE          = 8'd0,
        CFG_MISSING_CODE      = 8'd1,
        CFG_SUBSTITUTE_ENABLE = 8'd2,
        CFG_REPLACEMENT_VALUE = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] bad_code;
        logic signed [DATA_W-1:0] missing_code;
        logic                     substitute_enable;
        logic signed [DATA_W-1:0] replacement_value;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } t_back_state;

endpackage
`default_nettype wire

// ----- rtl/core/cmm_if.sv -----
// Valid/ready channel interfaces: samples in, column results out, register writes.
`default_nettype none
interface cmm_sample_if;
    import cmm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;
    logic                     last_level;
    modport source (output valid, output sample, output last_level, input ready);
    modport sink   (input valid, input sample, input last_level, output ready);
endinterface

interface cmm_result_if;
    import cmm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] column_mean;
    logic                     column_empty;
    logic [COUNT_OUT_W-1:0]   levels_counted;
    logic                     level_overflow;
    modport source (output valid, output column_mean, output column_empty,
                    output levels_counted, output level_overflow, input ready);
    modport sink   (input valid, input column_mean, input column_empty,
                    input levels_counted, input level_overflow, output ready);
endinterface

interface cmm_cfg_if;
    import cmm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/cmm_front.sv -----
// Front end: classifies samples and accumulates the sum and count of a column.
`default_nettype none
module cmm_front #(
    parameter int unsigned MAX_LEVELS  = 64,
    parameter int unsigned SAMPLE_BITS = 32,
    parameter int unsigned SUM_W       = 38,
    parameter int unsigned CNT_W       = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cmm_pkg::t_cfg i_cfg,
    cmm_sample_if.sink         i_in,
    input  wire logic          i_full,
    output logic               o_push,
    output logic [SUM_W+CNT_W:0] o_push_data
);
    import cmm_pkg::*;

    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_ovf, n_ovf;
    logic signed [DATA_W-1:0] s_ext;
    logic signed [DATA_W-1:0] add_v;
    logic                     is_code, take, at_max, counted, beat;

    assign i_in.ready = !i_full;
    assign beat       = i_in.valid && i_in.ready;

    always_comb begin
        s_ext   = DATA_W'(signed'(i_in.sample[SAMPLE_BITS-1:0]));
        is_code = (s_ext == i_cfg.bad_code) || (s_ext == i_cfg.missing_code);
        take    = !is_code || i_cfg.substitute_enable;
        add_v   = is_code ? i_cfg.replacement_value : s_ext;
        at_max  = (r_cnt == CNT_W'(MAX_LEVELS));
        counted = take && !at_max;
        n_sum   = counted ? (r_sum + SUM_W'(add_v)) : r_sum;
        n_cnt   = counted ? CNT_W'(r_cnt + 1'b1) : r_cnt;
        n_ovf   = r_ovf | (take & at_max);
    end

    assign o_push      = beat && i_in.last_level;
    assign o_push_data = {n_sum, n_cnt, n_ovf};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (beat) begin
            // clear after the last level, otherwise keep accumulating
            if (i_in.last_level) begin
                r_sum <= '0;
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/cmm_fifo.sv -----
// Two-entry queue of finished column totals between front and back.
`default_nettype none
module cmm_fifo #(
    parameter int unsigned WIDTH = 46
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_push_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/cmm_back.sv -----
// Back end: bit-serial signed division of column sum by count, result register.
`default_nettype none
module cmm_back #(
    parameter int unsigned SUM_W = 38,
    parameter int unsigned CNT_W = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire cmm_pkg::t_cfg    i_cfg,
    input  wire logic             i_empty,
    input  wire logic [SUM_W+CNT_W:0] i_data,
    output logic                  o_pop,
    cmm_result_if.source          o_res
);
    import cmm_pkg::*;

    localparam int unsigned STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    t_back_state          r_state;
    logic [SUM_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_div;
    logic [STEP_W-1:0]    r_step;
    logic                 r_neg, r_ovf, r_col_empty;

    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_mean;
    logic                 r_out_empty;
    logic [COUNT_OUT_W-1:0] r_out_cnt;
    logic                 r_out_ovf;

    logic signed [SUM_W-1:0] in_sum;
    logic [CNT_W-1:0]     in_cnt;
    logic                 in_ovf;
    logic [SUM_W-1:0]     in_abs;
    logic [CNT_W:0]       trial;
    logic                 ge;
    logic [CNT_W:0]       trial_sub;
    logic [DATA_W-1:0]    q_low;
    logic                 out_free;

    assign {in_sum, in_cnt, in_ovf} = i_data;

    always_comb begin
        in_abs    = in_sum[SUM_W-1] ? SUM_W'(-in_sum) : SUM_W'(in_sum);
        trial     = {r_rem, r_quo[SUM_W-1]};
        ge        = (trial >= {1'b0, r_div});
        trial_sub = trial - {1'b0, r_div};
        q_low     = r_quo[DATA_W-1:0];
    end

    assign out_free = !r_out_valid || o_res.ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // drop the taken beat unless a new one replaces it
            if (r_out_valid && o_res.ready && !((r_state == S_FIN) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= (in_cnt == '0) ? S_FIN : S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_step == '0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_quo       <= in_abs;
                r_rem       <= '0;
                r_div       <= in_cnt;
                r_neg       <= in_sum[SUM_W-1];
                r_ovf       <= in_ovf;
                r_col_empty <= (in_cnt == '0);
                r_step      <= STEP_W'(SUM_W - 1);
            end
            S_DIV: begin
                // one quotient bit per cycle, restoring form
                r_rem  <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
                r_quo  <= {r_quo[SUM_W-2:0], ge};
                r_step <= r_step - 1'b1;
            end
            S_FIN: begin
                if (out_free) begin
                    r_out_empty <= r_col_empty;
                    r_out_ovf   <= r_ovf;
                    if (r_col_empty) begin
                        r_out_mean <= i_cfg.missing_code;
                        r_out_cnt  <= '0;
                    end else begin
                        r_out_mean <= r_neg ? (-q_low) : q_low;
                        r_out_cnt  <= COUNT_OUT_W'(r_div);
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.column_mean    = r_out_mean;
    assign o_res.column_empty   = r_out_empty;
    assign o_res.levels_counted = r_out_cnt;
    assign o_res.level_overflow = r_out_ovf;

endmodule
`default_nettype wire

// ----- rtl/core/column_masked_mean_unit.sv -----
// Column masked mean unit: top level with register file, front, queue and back.
//
// Samples of one column arrive on i_in, one beat per level, the final level
// flagged by last_level. A sample equal to bad_code or missing_code is skipped,
// or counted as replacement_value when substitute_enable is set.
// One result beat per column leaves on o_res: the truncated mean, or
// missing_code with column_empty set when no level was counted.
// Registers are written through i_cfg, which is always ready. The user must
// ensure registers are written only while idle; the block does not enforce it.
// The front takes one sample per cycle while the queue has room. A column's
// totals go into a two-entry queue; the back divides them one quotient bit per
// cycle in a serial divider, and an empty column skips the divider.
// The back steps through S_IDLE, S_DIV and S_FIN and registers the result.
// The front stalls only while the queue holds two columns.
// A stalled receiver holds the result in the output register; the back keeps
// a finished quotient until that register frees.
// Reset is synchronous, clears the running totals, the queue and the output,
// and loads the register defaults.
`default_nettype none
module column_masked_mean_unit #(
    parameter int unsigned MAX_LEVELS  = 64,
    parameter int unsigned SAMPLE_BITS = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    cmm_sample_if.sink    i_in,
    cmm_result_if.source  o_res,
    cmm_cfg_if.sink       i_cfg
);
    import cmm_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_LEVELS + 1);
    localparam int unsigned SUM_W = DATA_W + $clog2(MAX_LEVELS);
    localparam int unsigned Q_W   = SUM_W + CNT_W + 1;

    t_cfg             r_cfg;
    logic             push, pop, full, empty;
    logic [Q_W-1:0]   push_data, pop_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bad_code          <= DATA_W'(32'h8000_0000);
            r_cfg.missing_code      <= DATA_W'(32'h8000_0001);
            r_cfg.substitute_enable <= 1'b0;
            r_cfg.replacement_value <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_BAD_CODE:          r_cfg.bad_code          <= i_cfg.data;
                CFG_MISSING_CODE:      r_cfg.missing_code      <= i_cfg.data;
                CFG_SUBSTITUTE_ENABLE: r_cfg.substitute_enable <= i_cfg.data[0];
                CFG_REPLACEMENT_VALUE: r_cfg.replacement_value <= i_cfg.data;
                default: ;
            endcase
        end
    end

    cmm_front #(
        .MAX_LEVELS  (MAX_LEVELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .i_full      (full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    cmm_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_full      (full),
        .o_empty     (empty),
        .o_data      (pop_data)
    );

    cmm_back #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_data  (pop_data),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire

// ----- rtl/core/cmm_checker.sv -----
// Port-level checks of the column masked mean unit, bound to the top level.
`default_nettype none
module cmm_checker #(
    parameter int unsigned MAX_LEVELS = 64
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [cmm_pkg::DATA_W-1:0]    i_mean,
    input wire logic                          i_empty,
    input wire logic [cmm_pkg::COUNT_OUT_W-1:0] i_count,
    input wire logic                          i_ovf
);
    import cmm_pkg::*;

    // hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_mean)
            && $stable(i_empty) && $stable(i_count) && $stable(i_ovf))
        else $error("result beat changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_empty |-> (i_count == '0) && !i_ovf)
        else $error("empty column with count or overflow");

    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_empty && (MAX_LEVELS < 128) |-> (i_count != '0))
        else $error("non-empty column with zero count");

    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ovf |->
            !i_empty && (i_count == COUNT_OUT_W'(MAX_LEVELS)))
        else $error("overflow without a full count");

endmodule

bind column_masked_mean_unit cmm_checker #(
    .MAX_LEVELS (MAX_LEVELS)
) u_cmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_mean      (o_res.column_mean),
    .i_empty     (o_res.column_empty),
    .i_count     (o_res.levels_counted),
    .i_ovf       (o_res.level_overflow)
);
`default_nettype wire

// ----- tb/sv/tb_column_masked_mean_unit.sv -----
// Self-checking testbench of the column masked mean unit: random columns, predicted means.
module tb_column_masked_mean_unit;
    import cmm_pkg::*;

    localparam int unsigned MAX_LEVELS   = 64;
    localparam int unsigned SAMPLE_BITS  = 32;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned STUCK_LIMIT  = 3000;
    localparam int unsigned HOLD_OFF_LEN = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hC4;

    typedef struct {
        logic signed [DATA_W-1:0] sample;
        logic                     last;
    } t_level;

    typedef struct {
        logic signed [DATA_W-1:0] mean;
        logic                     empty;
        logic [COUNT_OUT_W-1:0]   levels;
        logic                     overflow;
    } t_column_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cmm_sample_if samples_if ();
    cmm_result_if results_if ();
    cmm_cfg_if    cfg_if ();

    column_masked_mean_unit #(
        .MAX_LEVELS  (MAX_LEVELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (samples_if),
        .o_res   (results_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Register copies as the block holds them
    logic signed [DATA_W-1:0] reg_bad_code    = 32'sh8000_0000;
    logic signed [DATA_W-1:0] reg_missing     = 32'sh8000_0001;
    logic                     reg_substitute  = 1'b0;
    logic signed [DATA_W-1:0] reg_replacement = 32'sh0;

    // Totals of the column being accumulated
    longint      col_sum      = 0;
    int unsigned col_count    = 0;
    logic        col_overflow = 1'b0;

    t_level         pending_levels[$];
    t_column_result expected_means[$];
    int unsigned    mismatch_count  = 0;
    int unsigned    send_idle_pct   = 11;
    int unsigned    recv_idle_pct   = 54;
    logic           hold_off_armed  = 1'b0;
    int unsigned    hold_off_cycles = 0;
    int unsigned    stuck_cycles    = 0;

    function automatic void accumulate_level(logic signed [DATA_W-1:0] raw, logic last);
        logic signed [DATA_W-1:0] smp;
        logic signed [DATA_W-1:0] addend;
        logic                     take;
        longint                   quotient;
        t_column_result           res;
        smp    = raw <<< (DATA_W - SAMPLE_BITS);
        smp    = smp >>> (DATA_W - SAMPLE_BITS);
        take   = 1'b1;
        addend = smp;
        if (smp == reg_bad_code || smp == reg_missing) begin
            if (reg_substitute) addend = reg_replacement;
            else take = 1'b0;
        end
        if (take) begin
            if (col_count >= MAX_LEVELS) begin
                col_overflow = 1'b1;
            end else begin
                col_sum   += addend;
                col_count += 1;
            end
        end
        if (last) begin
            if (col_count == 0) begin
                res.mean   = reg_missing;
                res.empty  = 1'b1;
                res.levels = '0;
            end else begin
                quotient   = col_sum / longint'(col_count);
                res.mean   = quotient[DATA_W-1:0];
                res.empty  = 1'b0;
                res.levels = col_count[COUNT_OUT_W-1:0];
            end
            res.overflow = col_overflow;
            expected_means.push_back(res);
            col_sum      = 0;
            col_count    = 0;
            col_overflow = 1'b0;
        end
    endfunction

    // Sample driver: predict on each accepted beat, then offer the next level
    always @(posedge i_clk) begin
        t_level offered_level;
        if (!i_rst_n) begin
            samples_if.valid <= 1'b0;
        end else begin
            if (samples_if.valid && samples_if.ready)
                accumulate_level(samples_if.sample, samples_if.last_level);
            if (!samples_if.valid || samples_if.ready) begin
                if (pending_levels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_level = pending_levels.pop_front();
                    samples_if.valid      <= 1'b1;
                    samples_if.sample     <= offered_level.sample;
                    samples_if.last_level <= offered_level.last;
                end else begin
                    samples_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random back-pressure plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            results_if.ready <= 1'b0;
        end else if (hold_off_armed && hold_off_cycles < HOLD_OFF_LEN) begin
            hold_off_cycles  <= hold_off_cycles + 1;
            results_if.ready <= 1'b0;
        end else begin
            results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_column_result want;
        if (i_rst_n && results_if.valid && results_if.ready) begin
            if (expected_means.size() == 0) begin
                $error("column_mean: expected no beat, got %0d", results_if.column_mean);
                mismatch_count++;
            end else begin
                want = expected_means.pop_front();
                if (results_if.column_mean !== want.mean) begin
                    $error("column_mean: expected %0d, got %0d",
                           want.mean, results_if.column_mean);
                    mismatch_count++;
                end
                if (results_if.column_empty !== want.empty) begin
                    $error("column_empty: expected %0d, got %0d",
                           want.empty, results_if.column_empty);
                    mismatch_count++;
                end
                if (results_if.levels_counted !== want.levels) begin
                    $error("levels_counted: expected %0d, got %0d",
                           want.levels, results_if.levels_counted);
                    mismatch_count++;
                end
                if (results_if.level_overflow !== want.overflow) begin
                    $error("level_overflow: expected %0d, got %0d",
                           want.overflow, results_if.level_overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (samples_if.valid && samples_if.ready)
                || (results_if.valid && results_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_column_masked_mean_unit: errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_BAD_CODE:          reg_bad_code    = value;
            CFG_MISSING_CODE:      reg_missing     = value;
            CFG_SUBSTITUTE_ENABLE: reg_substitute  = value[0];
            CFG_REPLACEMENT_VALUE: reg_replacement = value;
            default: ;
        endcase
    endtask

    task automatic configure(logic [DATA_W-1:0] bad, logic [DATA_W-1:0] missing,
                             logic substitute, logic [DATA_W-1:0] replacement);
        write_register(CFG_BAD_CODE, bad);
        write_register(CFG_MISSING_CODE, missing);
        write_register(CFG_SUBSTITUTE_ENABLE, {{(DATA_W-1){1'b0}}, substitute});
        write_register(CFG_REPLACEMENT_VALUE, replacement);
        @(negedge i_clk);
    endtask

    task automatic push_level(logic signed [DATA_W-1:0] smp, logic last);
        t_level lvl;
        lvl.sample = smp;
        lvl.last   = last;
        pending_levels.push_back(lvl);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_sample(int unsigned code_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < code_pct / 2) return reg_bad_code;
        if (r < code_pct) return reg_missing;
        case ($urandom_range(7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0;
            3:       return -32'sd1;
            4, 5:    return int'($urandom_range(2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(int unsigned n_items);
        int unsigned queued;
        int unsigned levels;
        int unsigned code_pct;
        int unsigned pick;
        queued = 0;
        while (queued < n_items) begin
            pick = $urandom_range(99);
            if (pick < 85) levels = $urandom_range(6, 1);
            else if (pick < 95) levels = $urandom_range(20, 7);
            else levels = $urandom_range(80, 62);
            case ($urandom_range(3))
                0:       code_pct = 0;
                1:       code_pct = 15;
                2:       code_pct = 50;
                default: code_pct = 100;
            endcase
            // keep long columns mostly countable so they run past the level limit
            if (levels > 20) code_pct = $urandom_range(20);
            for (int i = 0; i < levels; i++)
                push_level(pick_sample(code_pct), i == levels - 1);
            queued += levels;
        end
    endtask

    task automatic wait_idle();
        while (pending_levels.size() != 0 || samples_if.valid || expected_means.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register defaults: single levels, empty columns, extremes
        push_level(32'sh7FFF_FFFF, 1'b1);
        push_level(32'sh8000_0000, 1'b1);
        push_level(32'sh8000_0001, 1'b0);
        push_level(32'sd5, 1'b0);
        push_level(-32'sd8, 1'b1);
        push_level(32'sh8000_0002, 1'b0);
        push_level(32'sh8000_0002, 1'b0);
        push_level(32'sh7FFF_FFFF, 1'b1);
        push_level(-32'sd7, 1'b0);
        push_level(32'sd0, 1'b1);
        push_level(32'sh8000_0000, 1'b0);
        push_level(32'sh8000_0001, 1'b1);
        queue_random(200);
        wait_idle();

        // Substitution on with the largest replacement
        configure(32'h0, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF);
        push_level(32'sd0, 1'b0);
        push_level(-32'sd1, 1'b0);
        push_level(32'sh7FFF_FFFF, 1'b1);
        push_level(-32'sd1, 1'b1);
        queue_random(200);
        wait_idle();

        send_idle_pct = 54;
        recv_idle_pct = 11;
        // Both codes equal, most negative replacement
        configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000);
        push_level(32'sh7FFF_FFFF, 1'b0);
        push_level(32'sd3, 1'b1);
        push_level(32'sh7FFF_FFFF, 1'b1);
        queue_random(200);
        wait_idle();

        configure($urandom, $urandom, 1'b0, $urandom);
        write_register(CFG_IDX_UNUSED, $urandom);
        @(negedge i_clk);
        queue_random(200);
        wait_idle();

        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_off_armed = 1'b1;
        configure(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        queue_random(200);
        wait_idle();

        configure($urandom, $urandom, 1'($urandom_range(1)), $urandom);
        queue_random(200);
        wait_idle();

        if (mismatch_count == 0)
            $display("tb_column_masked_mean_unit: clean");
        else
            $display("tb_column_masked_mean_unit: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/cmm_pkg.sv
rtl/core/cmm_if.sv
rtl/core/cmm_front.sv
rtl/core/cmm_fifo.sv
rtl/core/cmm_back.sv
rtl/core/column_masked_mean_unit.sv
rtl/core/cmm_checker.sv
tb/sv/tb_column_masked_mean_unit.sv
